// ===== src/rcbd_pkg.sv =====
package rcbd_pkg;

   localparam int PIX_W   = 8;
   localparam int SUM_W   = 32;
   localparam int CSR_W   = 16;
   localparam int PAUSE_W = 16;
   localparam int SPEED_W = 4;
   localparam int IDX_W   = 3;

   localparam logic [PAUSE_W-1:0] STOP_FRAMES_RST = 16'd10;
   localparam logic [PAUSE_W-1:0] HOLD_FRAMES_RST = 16'd20;
   localparam logic [SPEED_W-1:0] TURN_SPEED_RST  = 4'd4;

   typedef enum logic [IDX_W-1:0] {
      CSR_COL_START   = 3'd0,
      CSR_COL_END     = 3'd1,
      CSR_ROW_START   = 3'd2,
      CSR_ROW_END     = 3'd3,
      CSR_STOP_FRAMES = 3'd4,
      CSR_HOLD_FRAMES = 3'd5,
      CSR_TURN_SPEED  = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      COLOR_RED   = 2'd0,
      COLOR_GREEN = 2'd1,
      COLOR_BLUE  = 2'd2,
      COLOR_NONE  = 2'd3
   } color_type;

   typedef struct packed {
      logic [SUM_W-1:0] red;
      logic [SUM_W-1:0] green;
      logic [SUM_W-1:0] blue;
      logic             no_image;
   } frame_type;

   function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] sum,
                                                 input logic [PIX_W-1:0] pix);
      logic [SUM_W:0] s;
      s = {1'b0, sum} + {{(SUM_W+1-PIX_W){1'b0}}, pix};
      return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
   endfunction

   function automatic logic dominates(input logic [SUM_W-1:0] a,
                                      input logic [SUM_W-1:0] b,
                                      input logic [SUM_W-1:0] c);
      logic [SUM_W+1:0] a_x;
      logic [SUM_W+1:0] b3;
      logic [SUM_W+1:0] c3;
      a_x = {2'b00, a};
      b3  = {1'b0, b, 1'b0} + {2'b00, b};
      c3  = {1'b0, c, 1'b0} + {2'b00, c};
      return (a_x > b3) && (a_x > c3);
   endfunction

endpackage

// ===== src/rcbd_accum.sv =====
module rcbd_accum #(
   parameter int COORD_BITS = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         take,
   input  logic [rcbd_pkg::PIX_W-1:0]   red,
   input  logic [rcbd_pkg::PIX_W-1:0]   green,
   input  logic [rcbd_pkg::PIX_W-1:0]   blue,
   input  logic [COORD_BITS-1:0]        col,
   input  logic [COORD_BITS-1:0]        row,
   input  logic                         last_pixel,
   input  logic                         no_image,
   input  logic [COORD_BITS-1:0]        col_start,
   input  logic [COORD_BITS:0]          col_end,
   input  logic [COORD_BITS-1:0]        row_start,
   input  logic [COORD_BITS:0]          row_end,
   input  logic                         snap_take,
   output logic                         snap_valid,
   output rcbd_pkg::frame_type          snap
);

   logic [rcbd_pkg::SUM_W-1:0] red_total_ff, red_total_in;
   logic [rcbd_pkg::SUM_W-1:0] green_total_ff, green_total_in;
   logic [rcbd_pkg::SUM_W-1:0] blue_total_ff, blue_total_in;
   logic [rcbd_pkg::SUM_W-1:0] red_sum, green_sum, blue_sum;
   logic                       snap_valid_ff, snap_valid_in;
   rcbd_pkg::frame_type        snap_ff, snap_in;
   logic                       in_window;
   logic                       decide;

   assign in_window = !no_image
                      && (col >= col_start) && ({1'b0, col} < col_end)
                      && (row >= row_start) && ({1'b0, row} < row_end);
   assign decide = no_image || last_pixel;

   always_comb begin
      red_sum   = in_window ? rcbd_pkg::sat_add(red_total_ff, red) : red_total_ff;
      green_sum = in_window ? rcbd_pkg::sat_add(green_total_ff, green) : green_total_ff;
      blue_sum  = in_window ? rcbd_pkg::sat_add(blue_total_ff, blue) : blue_total_ff;
   end

   always_comb begin
      red_total_in   = red_total_ff;
      green_total_in = green_total_ff;
      blue_total_in  = blue_total_ff;
      snap_in        = snap_ff;
      snap_valid_in  = snap_valid_ff && !snap_take;
      if (take) begin
         if (decide) begin
            red_total_in     = '0;
            green_total_in   = '0;
            blue_total_in    = '0;
            snap_in.red      = red_sum;
            snap_in.green    = green_sum;
            snap_in.blue     = blue_sum;
            snap_in.no_image = no_image;
            snap_valid_in    = 1'b1;
         end else begin
            red_total_in   = red_sum;
            green_total_in = green_sum;
            blue_total_in  = blue_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         red_total_ff   <= '0;
         green_total_ff <= '0;
         blue_total_ff  <= '0;
         snap_valid_ff  <= 1'b0;
      end else begin
         red_total_ff   <= red_total_in;
         green_total_ff <= green_total_in;
         blue_total_ff  <= blue_total_in;
         snap_valid_ff  <= snap_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      snap_ff <= snap_in;
   end

   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;

endmodule

// ===== src/roi_color_blob_detector_top.sv =====
// Two register stages: the word that ends a frame registers the frame sums, and the result
// word is registered from them. Throughput: one input word per cycle, but when a result
// word waits on the result side and a second frame decision is already held, the input side
// stalls. Reset clears the sums, the pause count and both valid flags, and loads the
// configuration registers with their default values.
module roi_color_blob_detector_top #(
   parameter int COORD_BITS = 12
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [rcbd_pkg::PIX_W-1:0]     req_red,
   input  logic [rcbd_pkg::PIX_W-1:0]     req_green,
   input  logic [rcbd_pkg::PIX_W-1:0]     req_blue,
   input  logic [COORD_BITS-1:0]          req_col,
   input  logic [COORD_BITS-1:0]          req_row,
   input  logic                           req_last_pixel,
   input  logic                           req_no_image,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [rcbd_pkg::SPEED_W:0] rsp_left_speed,
   output logic [rcbd_pkg::SPEED_W-1:0]   rsp_right_speed,
   output logic [1:0]                     rsp_blob_color,
   output logic [rcbd_pkg::PAUSE_W-1:0]   rsp_pause_left,
   input  logic                           csr_we,
   input  logic [rcbd_pkg::IDX_W-1:0]     csr_index,
   input  logic [rcbd_pkg::CSR_W-1:0]     csr_data
);

   logic [COORD_BITS-1:0]          col_start_ff, col_start_in;
   logic [COORD_BITS:0]            col_end_ff, col_end_in;
   logic [COORD_BITS-1:0]          row_start_ff, row_start_in;
   logic [COORD_BITS:0]            row_end_ff, row_end_in;
   logic [rcbd_pkg::PAUSE_W-1:0]   stop_frames_ff, stop_frames_in;
   logic [rcbd_pkg::PAUSE_W-1:0]   hold_frames_ff, hold_frames_in;
   logic [rcbd_pkg::SPEED_W-1:0]   turn_speed_ff, turn_speed_in;

   logic [rcbd_pkg::PAUSE_W-1:0]   pause_ff, pause_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [rcbd_pkg::SPEED_W:0] left_ff, left_in;
   logic [rcbd_pkg::SPEED_W-1:0]   right_ff, right_in;
   rcbd_pkg::color_type            color_ff, color_in;
   logic [rcbd_pkg::PAUSE_W-1:0]   pause_left_ff, pause_left_in;

   logic                           out_free;
   logic                           snap_valid;
   logic                           snap_take;
   logic                           req_take;
   rcbd_pkg::frame_type            snap;
   logic [rcbd_pkg::PAUSE_W-1:0]   pause_dec;
   rcbd_pkg::color_type            color_sel;
   logic                           turning;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign snap_take = snap_valid && out_free;
   assign req_ready = !snap_valid || out_free;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      col_start_in   = col_start_ff;
      col_end_in     = col_end_ff;
      row_start_in   = row_start_ff;
      row_end_in     = row_end_ff;
      stop_frames_in = stop_frames_ff;
      hold_frames_in = hold_frames_ff;
      turn_speed_in  = turn_speed_ff;
      if (csr_we) begin
         case (rcbd_pkg::csr_index_type'(csr_index))
            rcbd_pkg::CSR_COL_START:   col_start_in   = csr_data[COORD_BITS-1:0];
            rcbd_pkg::CSR_COL_END:     col_end_in     = csr_data[COORD_BITS:0];
            rcbd_pkg::CSR_ROW_START:   row_start_in   = csr_data[COORD_BITS-1:0];
            rcbd_pkg::CSR_ROW_END:     row_end_in     = csr_data[COORD_BITS:0];
            rcbd_pkg::CSR_STOP_FRAMES: stop_frames_in = csr_data[rcbd_pkg::PAUSE_W-1:0];
            rcbd_pkg::CSR_HOLD_FRAMES: hold_frames_in = csr_data[rcbd_pkg::PAUSE_W-1:0];
            rcbd_pkg::CSR_TURN_SPEED:  turn_speed_in  = csr_data[rcbd_pkg::SPEED_W-1:0];
            default: ;
         endcase
      end
   end

   rcbd_accum #(
      .COORD_BITS (COORD_BITS)
   ) u_accum (
      .clock      (clock),
      .reset      (reset),
      .take       (req_take),
      .red        (req_red),
      .green      (req_green),
      .blue       (req_blue),
      .col        (req_col),
      .row        (req_row),
      .last_pixel (req_last_pixel),
      .no_image   (req_no_image),
      .col_start  (col_start_ff),
      .col_end    (col_end_ff),
      .row_start  (row_start_ff),
      .row_end    (row_end_ff),
      .snap_take  (snap_take),
      .snap_valid (snap_valid),
      .snap       (snap)
   );

   assign pause_dec = (pause_ff != '0) ? pause_ff - 1'b1 : pause_ff;

   always_comb begin
      if (rcbd_pkg::dominates(snap.red, snap.green, snap.blue)) begin
         color_sel = rcbd_pkg::COLOR_RED;
      end else if (rcbd_pkg::dominates(snap.green, snap.red, snap.blue)) begin
         color_sel = rcbd_pkg::COLOR_GREEN;
      end else if (rcbd_pkg::dominates(snap.blue, snap.red, snap.green)) begin
         color_sel = rcbd_pkg::COLOR_BLUE;
      end else begin
         color_sel = rcbd_pkg::COLOR_NONE;
      end
   end

   always_comb begin
      pause_in = pause_dec;
      color_in = rcbd_pkg::COLOR_NONE;
      turning  = 1'b0;
      if (pause_dec > stop_frames_ff) begin
         turning = 1'b0;
      end else if (pause_dec != '0) begin
         turning = 1'b1;
      end else if (snap.no_image) begin
         turning = 1'b0;
      end else begin
         color_in = color_sel;
         if (color_sel == rcbd_pkg::COLOR_NONE) begin
            turning = 1'b1;
         end else begin
            pause_in = hold_frames_ff;
         end
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      left_in       = left_ff;
      right_in      = right_ff;
      pause_left_in = pause_left_ff;
      if (snap_take) begin
         rsp_valid_in  = 1'b1;
         left_in       = turning ? -$signed({1'b0, turn_speed_ff}) : '0;
         right_in      = turning ? turn_speed_ff : '0;
         pause_left_in = pause_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_start_ff   <= '0;
         col_end_ff     <= '0;
         row_start_ff   <= '0;
         row_end_ff     <= '0;
         stop_frames_ff <= rcbd_pkg::STOP_FRAMES_RST;
         hold_frames_ff <= rcbd_pkg::HOLD_FRAMES_RST;
         turn_speed_ff  <= rcbd_pkg::TURN_SPEED_RST;
         pause_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         col_start_ff   <= col_start_in;
         col_end_ff     <= col_end_in;
         row_start_ff   <= row_start_in;
         row_end_ff     <= row_end_in;
         stop_frames_ff <= stop_frames_in;
         hold_frames_ff <= hold_frames_in;
         turn_speed_ff  <= turn_speed_in;
         if (snap_take) begin
            pause_ff <= pause_in;
         end
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff       <= left_in;
      right_ff      <= right_in;
      pause_left_ff <= pause_left_in;
      if (snap_take) begin
         color_ff <= color_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_left_speed  = left_ff;
   assign rsp_right_speed = right_ff;
   assign rsp_blob_color  = color_ff;
   assign rsp_pause_left  = pause_left_ff;

   a_speed_pair : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_left_speed == -$signed({1'b0, rsp_right_speed}))
      else $error("left and right wheel speeds disagree");

   a_blob_stops : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_blob_color != rcbd_pkg::COLOR_NONE) |->
         rsp_right_speed == '0 && rsp_pause_left == hold_frames_ff)
      else $error("blob word does not stop and reload the pause");

   a_pause_tracks : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $rose(rsp_valid) |-> rsp_pause_left == pause_ff)
      else $error("result pause differs from the pause count");

   a_snap_held : assert property (@(posedge clock) disable iff (reset)
      snap_valid && !out_free |=> snap_valid && $stable(snap))
      else $error("pending frame sums lost under stall");

endmodule
